[rtl/ksar_pkg.sv]
`default_nettype none

package ksar_pkg;

   localparam int KEY_W        = 10;
   localparam int CFG_W        = 8;
   localparam int IDLE_W       = 16;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [KEY_W-1:0]  ABLR_MASK             = 10'h303;
   localparam logic [KEY_W-1:0]  NON_START_SELECT_MASK = 10'h3F3;
   localparam logic [CFG_W-1:0]  DELAY_RESET           = 8'd12;
   localparam logic [CFG_W-1:0]  INTERVAL_RESET        = 8'd4;
   localparam logic [IDLE_W-1:0] IDLE_MAX              = '1;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_CLEAR  = 1'b1
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HOLD_DELAY  = 2'd0,
      CSR_TICK_PERIOD = 2'd1
   } csr_index_type;

   typedef logic [KEY_W-1:0] key_mask_type;

   typedef struct packed {
      key_mask_type        held_keys;
      key_mask_type        previous_keys;
      key_mask_type        pressed_keys;
      key_mask_type        repeated_keys;
      key_mask_type        combo_release;
      key_mask_type        toggle_pressed;
      logic [IDLE_W-1:0]   idle_frames;
   } rsp_payload_type;

endpackage

`default_nettype wire

[rtl/ksar_channels.sv]
`default_nettype none

// Sample / clear request channel
interface ksar_req_if;
   import ksar_pkg::*;
   logic         valid;
   logic         ready;
   cmd_type      cmd;
   key_mask_type keys;

   modport source (output valid, cmd, keys, input ready);
   modport sink   (input valid, cmd, keys, output ready);
endinterface

// Result channel
interface ksar_rsp_if;
   import ksar_pkg::*;
   logic              valid;
   logic              ready;
   key_mask_type      held_keys;
   key_mask_type      previous_keys;
   key_mask_type      pressed_keys;
   key_mask_type      repeated_keys;
   key_mask_type      combo_release;
   key_mask_type      toggle_pressed;
   logic [IDLE_W-1:0] idle_frames;

   modport source (output valid, held_keys, previous_keys, pressed_keys, repeated_keys,
                   combo_release, toggle_pressed, idle_frames, input ready);
   modport sink   (input valid, held_keys, previous_keys, pressed_keys, repeated_keys,
                   combo_release, toggle_pressed, idle_frames, output ready);
endinterface

// Register write channel
interface ksar_csr_if;
   import ksar_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CFG_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/key_state_autorepeat.sv]
`default_nettype none

// Channel    | Dir | Payload                                        | Accepted when
// -----------+-----+------------------------------------------------+----------------------
// req_bus    | in  | cmd, keys                                      | valid && ready
// rsp_bus    | out | held/previous/pressed/repeated/combo/toggle,   | valid && ready
//            |     | idle_frames                                    |
// csr_bus    | in  | index, data (0 = hold_delay, 1 = tick_period)  | valid && ready (always)
//
// One beat in, one beat out. Each result is registered in the output stage before it shows on rsp_bus.
// A request is taken every cycle while the skid is empty: the key state updates in the accept cycle.
// Results go through a two-deep output stage (main + skid), so one more request is
// taken while a result is stalled; req ready drops only while the skid is occupied.
// Synchronous reset clears all key state, the countdown, the idle count and the
// output stage, and loads hold_delay = 12, tick_period = 4.

module key_state_autorepeat (
   input  wire             clock,
   input  wire             reset,
   ksar_req_if.sink        req_bus,
   ksar_rsp_if.source      rsp_bus,
   ksar_csr_if.sink        csr_bus
);
   import ksar_pkg::*;

   // configuration
   logic [CFG_W-1:0] hold_delay_ff, hold_delay_in;
   logic [CFG_W-1:0] tick_period_ff, tick_period_in;

   // key state
   key_mask_type      prev_ff, prev_in;
   key_mask_type      held_ff, held_in;
   key_mask_type      pressed_ff, pressed_in;
   key_mask_type      repeat_ff, repeat_in;
   key_mask_type      last_combo_ff, last_combo_in;
   key_mask_type      release_ff, release_in;
   key_mask_type      toggle_ff, toggle_in;
   logic [CFG_W-1:0]  countdown_ff, countdown_in;
   logic [IDLE_W-1:0] idle_ff, idle_in;

   // output stage
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff, out_data_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type skid_data_ff, skid_data_in;

   logic            push;
   logic            pop;
   rsp_payload_type new_result;
   logic [CFG_W-1:0] count_dec;
   key_mask_type    keys;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !skid_valid_ff;

   assign push = req_bus.valid && req_bus.ready;
   assign pop  = out_valid_ff && rsp_bus.ready;
   assign keys = req_bus.keys;

   // register writes; unknown indexes are dropped
   always_comb begin
      hold_delay_in  = hold_delay_ff;
      tick_period_in = tick_period_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_HOLD_DELAY:  hold_delay_in  = csr_bus.data;
            CSR_TICK_PERIOD: tick_period_in = csr_bus.data;
            default: ;
         endcase
      end
   end

   // next key state for the beat on req_bus
   always_comb begin
      prev_in       = prev_ff;
      held_in       = held_ff;
      pressed_in    = pressed_ff;
      repeat_in     = repeat_ff;
      last_combo_in = last_combo_ff;
      release_in    = release_ff;
      toggle_in     = toggle_ff;
      countdown_in  = countdown_ff;
      idle_in       = idle_ff;
      count_dec     = countdown_ff - 1'b1;

      unique case (req_bus.cmd)
         CMD_CLEAR: begin
            held_in    = '0;
            pressed_in = '0;
            repeat_in  = '0;
         end
         CMD_SAMPLE: begin
            prev_in    = held_ff;
            held_in    = keys;
            pressed_in = keys & ~held_ff;
            repeat_in  = keys & ~held_ff;
            if ((keys & ~held_ff) != '0) begin
               last_combo_in = keys;
            end

            // A/B/L/R-only combo let go completely
            release_in = '0;
            if (keys == '0 && last_combo_in != '0 &&
                last_combo_in == (held_ff & ABLR_MASK)) begin
               release_in = held_ff;
            end

            // same non-empty set held: count down, repeat on zero
            if (keys != '0 && keys == held_ff) begin
               countdown_in = count_dec;
               if (count_dec == '0) begin
                  repeat_in    = keys;
                  countdown_in = tick_period_ff;
               end
            end else begin
               countdown_in = hold_delay_ff;
            end

            toggle_in = keys & ~toggle_ff;

            if ((keys & NON_START_SELECT_MASK) != '0) begin
               idle_in = '0;
            end else if (idle_ff != IDLE_MAX) begin
               idle_in = idle_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      new_result.held_keys      = held_in;
      new_result.previous_keys  = prev_in;
      new_result.pressed_keys   = pressed_in;
      new_result.repeated_keys  = repeat_in;
      new_result.combo_release  = release_in;
      new_result.toggle_pressed = toggle_in;
      new_result.idle_frames    = idle_in;
   end

   // main + skid output stage; skid only fills while main is stalled
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         out_valid_in  = skid_valid_ff || push;
         out_data_in   = skid_valid_ff ? skid_data_ff : new_result;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = new_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_delay_ff      <= DELAY_RESET;
         tick_period_ff     <= INTERVAL_RESET;
         prev_ff            <= '0;
         held_ff            <= '0;
         pressed_ff         <= '0;
         repeat_ff          <= '0;
         last_combo_ff      <= '0;
         release_ff         <= '0;
         toggle_ff          <= '0;
         countdown_ff       <= '0;
         idle_ff            <= '0;
         out_valid_ff       <= 1'b0;
         skid_valid_ff      <= 1'b0;
      end else begin
         hold_delay_ff      <= hold_delay_in;
         tick_period_ff     <= tick_period_in;
         if (push) begin
            prev_ff       <= prev_in;
            held_ff       <= held_in;
            pressed_ff    <= pressed_in;
            repeat_ff     <= repeat_in;
            last_combo_ff <= last_combo_in;
            release_ff    <= release_in;
            toggle_ff     <= toggle_in;
            countdown_ff  <= countdown_in;
            idle_ff       <= idle_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.held_keys      = out_data_ff.held_keys;
   assign rsp_bus.previous_keys  = out_data_ff.previous_keys;
   assign rsp_bus.pressed_keys   = out_data_ff.pressed_keys;
   assign rsp_bus.repeated_keys  = out_data_ff.repeated_keys;
   assign rsp_bus.combo_release  = out_data_ff.combo_release;
   assign rsp_bus.toggle_pressed = out_data_ff.toggle_pressed;
   assign rsp_bus.idle_frames    = out_data_ff.idle_frames;

endmodule

`default_nettype wire

[rtl/ksar_checker.sv]
`default_nettype none

module ksar_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire [ksar_pkg::KEY_W-1:0]    held_keys,
   input wire [ksar_pkg::KEY_W-1:0]    pressed_keys,
   input wire [ksar_pkg::KEY_W-1:0]    repeated_keys,
   input wire [ksar_pkg::KEY_W-1:0]    combo_release,
   input wire [ksar_pkg::KEY_W-1:0]    toggle_pressed
);
   import ksar_pkg::*;

   // nothing comes out the cycle after reset
   a_quiet_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // new presses and repeats are always within the held set
   a_edges_in_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((pressed_keys | repeated_keys) & ~held_keys) == '0)
      else $error("pressed/repeated key not held");

   // a combo release is reported only once everything is let go
   a_release_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && combo_release != '0 |-> held_keys == '0)
      else $error("combo release with keys held");

   // the toggle mask lies within a non-empty held set; a clear keeps the toggle mask but empties the held set
   a_toggle_in_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && held_keys != '0 |-> (toggle_pressed & ~held_keys) == '0)
      else $error("toggle mask outside held set");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(held_keys))
      else $error("stalled result dropped or changed");

endmodule

bind key_state_autorepeat ksar_checker u_ksar_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .held_keys      (rsp_bus.held_keys),
   .pressed_keys   (rsp_bus.pressed_keys),
   .repeated_keys  (rsp_bus.repeated_keys),
   .combo_release  (rsp_bus.combo_release),
   .toggle_pressed (rsp_bus.toggle_pressed)
);

`default_nettype wire
